FILE: src/thq_pkg.sv
// Shared widths, item kind codes and register indexes for the terrain height query block.
package thq_pkg;

	localparam int MAX_COLUMNS = 256;
	localparam int MAX_ROWS    = 256;

	localparam int H_W      = 24;                    // Q15.8 height / coordinate
	localparam int ADDR_W   = 16;                    // store address
	localparam int DEPTH    = 1 << ADDR_W;
	localparam int CNT_W    = 9;                     // grid count registers
	localparam int SP_W     = 16;                    // spacing Q8.8
	localparam int DEN_W    = SP_W + 1;              // 2*spacing
	localparam int NUM_W    = 26;                    // non-negative cell numerator
	localparam int FRAC_W   = 16;                    // Q0.16 fraction
	localparam int QUOT_W   = NUM_W + FRAC_W;
	localparam int VERT_W   = $clog2(MAX_COLUMNS > MAX_ROWS ? MAX_COLUMNS : MAX_ROWS);
	localparam int ITER_W   = $clog2(QUOT_W);
	localparam int DATA_W   = 16;                    // configuration write data

	localparam logic [1:0] KIND_QUERY = 2'd0;
	localparam logic [1:0] KIND_LOAD  = 2'd1;
	localparam logic [1:0] KIND_ADD   = 2'd2;
	localparam logic [1:0] KIND_FLAT  = 2'd3;

	localparam logic [1:0] REG_COLUMNS = 2'd0;
	localparam logic [1:0] REG_ROWS    = 2'd1;
	localparam logic [1:0] REG_SPACING = 2'd2;

endpackage

FILE: src/terrain_height_query.sv
// Top level of the terrain height query block: control, address and interpolation datapath.
//
// Usage
//   Items enter on start while busy is low; kind selects query, load, add or
//   flatten. Load and flatten are written to the height store at the accepting
//   edge and leave busy low. Add reads the entry and writes the saturated sum
//   back in the next cycle (busy for one cycle, so the next item waits for it).
//   A query runs two bit-serial dividers in parallel (42 quotient bits, one
//   per cycle, until both finish), then clamps the cell, forms the base
//   address, reads the four corners from the single read port and does two
//   registered multiplies and a rounding sum. No new item is accepted while a
//   query runs; done is high for one cycle with height_out, and busy falls in
//   that same cycle, so the next item can be accepted at its end.
//   The receiver cannot stall; results are never held.
//   Configuration (wr_en, wr_index, wr_data) is written at any edge with
//   wr_en high and is expected only while the block is idle; index 3 is
//   ignored. Counts are clamped to 2..max, spacing 0 is taken as 1.
//   Reset clears control and restores the registers to 256/256/256; the
//   height store has no reset and reads of unwritten entries are undefined.
module terrain_height_query (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic [1:0]                       kind,
	input  logic [thq_pkg::ADDR_W-1:0]       vertex_index,
	input  logic signed [thq_pkg::H_W-1:0]   height_value,
	input  logic signed [thq_pkg::H_W-1:0]   pos_x,
	input  logic signed [thq_pkg::H_W-1:0]   pos_z,
	output logic                             done,
	output logic signed [thq_pkg::H_W-1:0]   height_out,
	input  logic                             wr_en,
	input  logic [1:0]                       wr_index,
	input  logic [thq_pkg::DATA_W-1:0]       wr_data
);

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_ADDW  = 4'd1;
	localparam logic [3:0] ST_DIV   = 4'd2;
	localparam logic [3:0] ST_CLAMP = 4'd3;
	localparam logic [3:0] ST_BASE  = 4'd4;
	localparam logic [3:0] ST_READ  = 4'd5;
	localparam logic [3:0] ST_MUL1  = 4'd6;
	localparam logic [3:0] ST_MUL2  = 4'd7;
	localparam logic [3:0] ST_SUM   = 4'd8;

	localparam int PROD_W = thq_pkg::H_W + 1 + thq_pkg::FRAC_W + 2;
	localparam int ACC_W  = PROD_W + 2;
	localparam int RND_W  = ACC_W - thq_pkg::FRAC_W;
	localparam logic [thq_pkg::FRAC_W:0] ONE = {1'b1, {thq_pkg::FRAC_W{1'b0}}};

	// configuration registers
	logic [thq_pkg::CNT_W-1:0] cols_q, rows_q;
	logic [thq_pkg::SP_W-1:0]  spacing_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q    <= thq_pkg::CNT_W'(256);
			rows_q    <= thq_pkg::CNT_W'(256);
			spacing_q <= thq_pkg::SP_W'(256);
		end else if (wr_en) begin
			case (wr_index)
				thq_pkg::REG_COLUMNS: cols_q    <= wr_data[thq_pkg::CNT_W-1:0];
				thq_pkg::REG_ROWS:    rows_q    <= wr_data[thq_pkg::CNT_W-1:0];
				thq_pkg::REG_SPACING: spacing_q <= wr_data;
				default: ;
			endcase
		end
	end

	// effective grid geometry
	logic [thq_pkg::CNT_W-1:0] cols_eff, rows_eff;
	logic [thq_pkg::SP_W-1:0]  sp_eff;

	always_comb begin
		cols_eff = cols_q;
		if (cols_q < thq_pkg::CNT_W'(2))
			cols_eff = thq_pkg::CNT_W'(2);
		else if (cols_q > thq_pkg::CNT_W'(thq_pkg::MAX_COLUMNS))
			cols_eff = thq_pkg::CNT_W'(thq_pkg::MAX_COLUMNS);
		rows_eff = rows_q;
		if (rows_q < thq_pkg::CNT_W'(2))
			rows_eff = thq_pkg::CNT_W'(2);
		else if (rows_q > thq_pkg::CNT_W'(thq_pkg::MAX_ROWS))
			rows_eff = thq_pkg::CNT_W'(thq_pkg::MAX_ROWS);
		sp_eff = (spacing_q == '0) ? thq_pkg::SP_W'(1) : spacing_q;
	end

	// control
	logic [3:0] state_q;
	logic       accept;
	logic [2:0] rd_cnt_q;
	logic [thq_pkg::ADDR_W-1:0]     idx_q;
	logic signed [thq_pkg::H_W-1:0] hv_q;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;

	// cell numerators in 1/512 units: (n-1)*sp +/- 2*pos
	localparam int NUM_W_S = thq_pkg::NUM_W + 1;
	localparam int SPAN_W  = thq_pkg::NUM_W - 1;
	logic signed [NUM_W_S-1:0] num_x, num_z;
	logic [SPAN_W-1:0] span_x, span_z;

	always_comb begin
		span_x = SPAN_W'(cols_eff - 1'b1) * SPAN_W'(sp_eff);
		span_z = SPAN_W'(rows_eff - 1'b1) * SPAN_W'(sp_eff);
		num_x = NUM_W_S'($signed({1'b0, span_x}))
			+ NUM_W_S'($signed({pos_x, 1'b0}));
		num_z = NUM_W_S'($signed({1'b0, span_z}))
			- NUM_W_S'($signed({pos_z, 1'b0}));
	end

	logic neg_x_q, neg_z_q;
	logic div_start;
	logic [thq_pkg::QUOT_W-1:0] quot_x, quot_z;
	logic div_done_x, div_done_z;
	logic [thq_pkg::DEN_W-1:0] den;

	assign den       = {sp_eff, 1'b0};
	assign div_start = accept && (kind == thq_pkg::KIND_QUERY);

	thq_div u_div_x (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.num      (num_x[thq_pkg::NUM_W-1:0]),
		.den      (den),
		.quot     (quot_x),
		.div_done (div_done_x)
	);

	thq_div u_div_z (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.num      (num_z[thq_pkg::NUM_W-1:0]),
		.den      (den),
		.quot     (quot_z),
		.div_done (div_done_z)
	);

	// clamp to the grid
	logic [thq_pkg::VERT_W-1:0] col_q, row_q;
	logic [thq_pkg::FRAC_W:0]   dx_q, dz_q;
	logic [thq_pkg::NUM_W-1:0]  qx, qz;
	logic [thq_pkg::CNT_W-1:0]  col_lim, row_lim;

	assign qx      = quot_x[thq_pkg::QUOT_W-1:thq_pkg::FRAC_W];
	assign qz      = quot_z[thq_pkg::QUOT_W-1:thq_pkg::FRAC_W];
	assign col_lim = cols_eff - thq_pkg::CNT_W'(2);
	assign row_lim = rows_eff - thq_pkg::CNT_W'(2);

	// corner addressing
	logic [thq_pkg::ADDR_W-1:0] base_q, rd_addr, mem_raddr, mem_waddr;
	logic signed [thq_pkg::H_W-1:0] mem_rdata, mem_wdata;
	logic mem_we;
	logic signed [thq_pkg::H_W-1:0] h_q [4];   // a, b, c, d

	always_comb begin
		case (rd_cnt_q)
			3'd0:    rd_addr = base_q;
			3'd1:    rd_addr = base_q + 1'b1;
			3'd2:    rd_addr = base_q + thq_pkg::ADDR_W'(cols_eff);
			default: rd_addr = base_q + thq_pkg::ADDR_W'(cols_eff) + 1'b1;
		endcase
	end

	// saturating add for edits
	logic signed [thq_pkg::H_W:0]   add_sum;
	logic signed [thq_pkg::H_W-1:0] add_sat;

	always_comb begin
		add_sum = {mem_rdata[thq_pkg::H_W-1], mem_rdata} + {hv_q[thq_pkg::H_W-1], hv_q};
		if (add_sum[thq_pkg::H_W] != add_sum[thq_pkg::H_W-1])
			add_sat = add_sum[thq_pkg::H_W] ? {1'b1, {(thq_pkg::H_W-1){1'b0}}}
				: {1'b0, {(thq_pkg::H_W-1){1'b1}}};
		else
			add_sat = add_sum[thq_pkg::H_W-1:0];
	end

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = vertex_index;
		mem_wdata = (kind == thq_pkg::KIND_LOAD) ? height_value : '0;
		mem_raddr = vertex_index;
		if (state_q == ST_ADDW) begin
			mem_we    = 1'b1;
			mem_waddr = idx_q;
			mem_wdata = add_sat;
		end else if (accept && (kind == thq_pkg::KIND_LOAD || kind == thq_pkg::KIND_FLAT)) begin
			mem_we = 1'b1;
		end
		if (state_q == ST_READ)
			mem_raddr = rd_addr;
	end

	thq_mem u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// triangle select: upper (a,b,c) when dx + dz < 1.0, else lower (d,c,b)
	logic upper;
	logic signed [thq_pkg::H_W-1:0] h0, h1, h2;
	logic [thq_pkg::FRAC_W:0]       f1, f2;
	logic signed [thq_pkg::H_W:0]   diff;
	logic [thq_pkg::FRAC_W:0]       fsel;
	logic signed [PROD_W-1:0]       prod;
	logic signed [PROD_W-1:0]       p1_q, p2_q;

	assign upper = ({1'b0, dx_q} + {1'b0, dz_q}) < {1'b0, ONE};

	always_comb begin
		if (upper) begin
			h0 = h_q[0]; h1 = h_q[1]; h2 = h_q[2];
			f1 = dx_q;   f2 = dz_q;
		end else begin
			h0 = h_q[3]; h1 = h_q[2]; h2 = h_q[1];
			f1 = ONE - dx_q; f2 = ONE - dz_q;
		end
		if (state_q == ST_MUL1) begin
			diff = {h1[thq_pkg::H_W-1], h1} - {h0[thq_pkg::H_W-1], h0};
			fsel = f1;
		end else begin
			diff = {h2[thq_pkg::H_W-1], h2} - {h0[thq_pkg::H_W-1], h0};
			fsel = f2;
		end
		prod = PROD_W'(diff * $signed({1'b0, fsel}));
	end

	// final sum, round to nearest (ties up), saturate
	logic signed [ACC_W-1:0] acc;
	logic signed [RND_W-1:0] rnd;
	logic signed [thq_pkg::H_W-1:0] hsat;

	always_comb begin
		acc = ACC_W'($signed({h0, {thq_pkg::FRAC_W{1'b0}}})) + ACC_W'(p1_q) + ACC_W'(p2_q)
			+ ACC_W'(1 << (thq_pkg::FRAC_W - 1));
		rnd = acc[ACC_W-1:thq_pkg::FRAC_W];
		if (rnd > RND_W'(8388607))
			hsat = {1'b0, {(thq_pkg::H_W-1){1'b1}}};
		else if (rnd < -RND_W'(8388608))
			hsat = {1'b1, {(thq_pkg::H_W-1){1'b0}}};
		else
			hsat = rnd[thq_pkg::H_W-1:0];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			rd_cnt_q <= '0;
			done     <= 1'b0;
		end else begin
			done <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (kind == thq_pkg::KIND_QUERY)
							state_q <= ST_DIV;
						else if (kind == thq_pkg::KIND_ADD)
							state_q <= ST_ADDW;
					end
				end
				ST_ADDW:  state_q <= ST_IDLE;
				ST_DIV:   if (div_done_x) state_q <= ST_CLAMP;
				ST_CLAMP: state_q <= ST_BASE;
				ST_BASE: begin
					rd_cnt_q <= '0;
					state_q  <= ST_READ;
				end
				ST_READ: begin
					rd_cnt_q <= rd_cnt_q + 1'b1;
					if (rd_cnt_q == 3'd4)
						state_q <= ST_MUL1;
				end
				ST_MUL1:  state_q <= ST_MUL2;
				ST_MUL2:  state_q <= ST_SUM;
				ST_SUM: begin
					done    <= 1'b1;
					state_q <= ST_IDLE;
				end
				default:  state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			idx_q   <= vertex_index;
			hv_q    <= height_value;
			neg_x_q <= num_x[thq_pkg::NUM_W];
			neg_z_q <= num_z[thq_pkg::NUM_W];
		end
		if (state_q == ST_CLAMP) begin
			if (neg_x_q) begin
				col_q <= '0;
				dx_q  <= '0;
			end else if (qx > thq_pkg::NUM_W'(col_lim)) begin
				col_q <= col_lim[thq_pkg::VERT_W-1:0];
				dx_q  <= ONE;
			end else begin
				col_q <= qx[thq_pkg::VERT_W-1:0];
				dx_q  <= {1'b0, quot_x[thq_pkg::FRAC_W-1:0]};
			end
			if (neg_z_q) begin
				row_q <= '0;
				dz_q  <= '0;
			end else if (qz > thq_pkg::NUM_W'(row_lim)) begin
				row_q <= row_lim[thq_pkg::VERT_W-1:0];
				dz_q  <= ONE;
			end else begin
				row_q <= qz[thq_pkg::VERT_W-1:0];
				dz_q  <= {1'b0, quot_z[thq_pkg::FRAC_W-1:0]};
			end
		end
		if (state_q == ST_BASE)
			base_q <= thq_pkg::ADDR_W'(row_q * cols_eff + col_q);
		if (state_q == ST_READ && rd_cnt_q != 3'd0)
			h_q[rd_cnt_q[1:0] - 2'd1] <= mem_rdata;
		if (state_q == ST_MUL1)
			p1_q <= prod;
		if (state_q == ST_MUL2)
			p2_q <= prod;
		if (state_q == ST_SUM)
			height_out <= hsat;
	end

	// checks
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n) done |-> !busy)
		else $error("result strobe while busy");
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && kind == thq_pkg::KIND_QUERY) |=> busy)
		else $error("query accepted but block not busy");
	a_edit_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && kind != thq_pkg::KIND_QUERY) |=> !done)
		else $error("edit transaction produced a result");
	a_div_pair: assert property (@(posedge clk) disable iff (!arst_n)
		div_done_x == div_done_z)
		else $error("dividers out of step");

endmodule

FILE: src/thq_mem.sv
// Height store: single write port, single registered read port.
module thq_mem (
	input  logic                             clk,
	input  logic                             we,
	input  logic [thq_pkg::ADDR_W-1:0]       waddr,
	input  logic signed [thq_pkg::H_W-1:0]   wdata,
	input  logic [thq_pkg::ADDR_W-1:0]       raddr,
	output logic signed [thq_pkg::H_W-1:0]   rdata
);

	logic signed [thq_pkg::H_W-1:0] mem [thq_pkg::DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: src/thq_div.sv
// Restoring divider, one quotient bit per cycle: quot = (num << 16) / den.
module thq_div (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic [thq_pkg::NUM_W-1:0]        num,
	input  logic [thq_pkg::DEN_W-1:0]        den,
	output logic [thq_pkg::QUOT_W-1:0]       quot,
	output logic                             div_done
);

	logic [thq_pkg::DEN_W:0]      rem_q;
	logic [thq_pkg::QUOT_W-1:0]   quot_q;
	logic [thq_pkg::DEN_W-1:0]    den_q;
	logic [thq_pkg::ITER_W-1:0]   cnt_q;
	logic                         run_q;
	logic                         done_q;
	logic [thq_pkg::DEN_W:0]      trial;
	logic                         fits;

	assign trial = {rem_q[thq_pkg::DEN_W-1:0], quot_q[thq_pkg::QUOT_W-1]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == thq_pkg::ITER_W'(thq_pkg::QUOT_W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= '0;
			quot_q <= {num, {thq_pkg::FRAC_W{1'b0}}};
			den_q  <= den;
		end else if (run_q) begin
			rem_q  <= fits ? trial - {1'b0, den_q} : trial;
			quot_q <= {quot_q[thq_pkg::QUOT_W-2:0], fits};
		end
	end

	assign quot     = quot_q;
	assign div_done = done_q;

endmodule

FILE: dv/tb_top.sv
// Self-checking testbench for terrain_height_query: edits, queries and grid settings.
module tb_top;

	// Expected query heights plus a private copy of the height grid and registers.
	class terrain_scoreboard;
		int errors;
		bit [thq_pkg::CNT_W-1:0] columns;
		bit [thq_pkg::CNT_W-1:0] rows;
		bit [thq_pkg::SP_W-1:0] spacing;
		int heights[int];                 // only entries that have been written
		logic signed [thq_pkg::H_W-1:0] pending_heights[$];

		function new();
			columns = 256;
			rows = 256;
			spacing = 256;
		endfunction

		task report(string msg);
			$display("mismatch: %s", msg);
			errors++;
		endtask

		function void write_reg(logic [1:0] idx, logic [thq_pkg::DATA_W-1:0] data);
			case (idx)
				thq_pkg::REG_COLUMNS: columns = data[thq_pkg::CNT_W-1:0];
				thq_pkg::REG_ROWS:    rows = data[thq_pkg::CNT_W-1:0];
				thq_pkg::REG_SPACING: spacing = data;
				default: ;
			endcase
		endfunction

		function longint clamp_count(longint v, longint hi);
			if (v < 2) return 2;
			if (v > hi) return hi;
			return v;
		endfunction

		function longint sat24(longint v);
			if (v > 8388607) return 8388607;
			if (v < -8388608) return -8388608;
			return v;
		endfunction

		// vertex and Q0.16 fraction along one axis
		function void cell_axis(longint num, longint den, longint cnt,
				output longint vert, output longint frac);
			if (num < 0) begin
				vert = 0;
				frac = 0;
			end else if (num / den > cnt - 2) begin
				vert = cnt - 2;
				frac = 65536;
			end else begin
				vert = num / den;
				frac = ((num % den) * 65536) / den;
			end
		endfunction

		// corner addresses A,B,C,D and fractions for a world position
		function void locate(longint x, longint z, output int addr[4],
				output longint dx, output longint dz);
			longint cols, rws, sp, col, row;
			cols = clamp_count(columns, thq_pkg::MAX_COLUMNS);
			rws = clamp_count(rows, thq_pkg::MAX_ROWS);
			sp = (spacing == 0) ? 1 : spacing;
			cell_axis((cols - 1) * sp + 2 * x, 2 * sp, cols, col, dx);
			cell_axis((rws - 1) * sp - 2 * z, 2 * sp, rws, row, dz);
			addr[0] = int'((row * cols + col) & 16'hFFFF);
			addr[1] = int'((row * cols + col + 1) & 16'hFFFF);
			addr[2] = int'(((row + 1) * cols + col) & 16'hFFFF);
			addr[3] = int'(((row + 1) * cols + col + 1) & 16'hFFFF);
		endfunction

		function longint interpolate(longint x, longint z);
			int addr[4];
			longint dx, dz, a, b, c, d, acc;
			locate(x, z, addr, dx, dz);
			a = heights[addr[0]];
			b = heights[addr[1]];
			c = heights[addr[2]];
			d = heights[addr[3]];
			if (dx + dz < 65536)
				acc = a * 65536 + (b - a) * dx + (c - a) * dz;
			else
				acc = d * 65536 + (c - d) * (65536 - dx) + (b - d) * (65536 - dz);
			return sat24((acc + 32768) >>> 16);
		endfunction

		// accepted transaction: update the grid copy or queue the expected height
		function void note_item(logic [1:0] k, logic [thq_pkg::ADDR_W-1:0] idx,
				logic signed [thq_pkg::H_W-1:0] hv, logic signed [thq_pkg::H_W-1:0] x,
				logic signed [thq_pkg::H_W-1:0] z);
			longint cur;
			case (k)
				thq_pkg::KIND_LOAD: heights[idx] = hv;
				thq_pkg::KIND_ADD: begin
					cur = heights.exists(idx) ? heights[idx] : 0;
					heights[idx] = int'(sat24(cur + hv));
				end
				thq_pkg::KIND_FLAT: heights[idx] = 0;
				default: pending_heights.push_back(thq_pkg::H_W'(interpolate(x, z)));
			endcase
		endfunction

		task check_height(logic signed [thq_pkg::H_W-1:0] got);
			logic signed [thq_pkg::H_W-1:0] want;
			if (pending_heights.size() == 0) begin
				report($sformatf("unexpected height %0d", got));
				return;
			end
			want = pending_heights.pop_front();
			if (got !== want)
				report($sformatf("height_out %0d, expected %0d", got, want));
		endtask
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic start = 0;
	logic busy;
	logic [1:0] kind = thq_pkg::KIND_QUERY;
	logic [thq_pkg::ADDR_W-1:0] vertex_index = '0;
	logic signed [thq_pkg::H_W-1:0] height_value = '0;
	logic signed [thq_pkg::H_W-1:0] pos_x = '0;
	logic signed [thq_pkg::H_W-1:0] pos_z = '0;
	logic done;
	logic signed [thq_pkg::H_W-1:0] height_out;
	logic wr_en = 0;
	logic [1:0] wr_index = thq_pkg::REG_COLUMNS;
	logic [thq_pkg::DATA_W-1:0] wr_data = '0;

	terrain_scoreboard heights_sb = new();
	bit idling_on = 1;

	terrain_height_query i_dut (
		.clk, .arst_n, .start, .busy, .kind, .vertex_index, .height_value,
		.pos_x, .pos_z, .done, .height_out, .wr_en, .wr_index, .wr_data
	);

	always #5 clk = ~clk;

	// results last one cycle and cannot be held off: sample mid-cycle
	always @(negedge clk) begin
		if (arst_n && done)
			heights_sb.check_height(height_out);
	end

	// one transaction; start stays high on return unless the next call idles
	task automatic send_item(logic [1:0] k, logic [thq_pkg::ADDR_W-1:0] idx,
			logic signed [thq_pkg::H_W-1:0] hv, logic signed [thq_pkg::H_W-1:0] x,
			logic signed [thq_pkg::H_W-1:0] z);
		if (idling_on && $urandom_range(99) < 23) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		start <= 1'b1;
		kind <= k;
		vertex_index <= idx;
		height_value <= hv;
		pos_x <= x;
		pos_z <= z;
		@(negedge clk);
		while (busy) @(negedge clk);
		@(posedge clk);
		heights_sb.note_item(k, idx, hv, x, z);
	endtask

	// drain: no transaction in flight, then allow for a trailing add
	task automatic wait_idle();
		start <= 1'b0;
		while (heights_sb.pending_heights.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [thq_pkg::DATA_W-1:0] data);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= data;
		@(posedge clk);
		heights_sb.write_reg(idx, data);
		wr_en <= 1'b0;
		@(posedge clk);
	endtask

	// never read an unwritten store entry: load any missing corner first
	task automatic query_at(logic signed [thq_pkg::H_W-1:0] x,
			logic signed [thq_pkg::H_W-1:0] z);
		int addr[4];
		longint dx, dz;
		heights_sb.locate(x, z, addr, dx, dz);
		foreach (addr[i]) begin
			if (!heights_sb.heights.exists(addr[i]))
				send_item(thq_pkg::KIND_LOAD, addr[i],
					thq_pkg::H_W'($urandom_range(20000)) - 24'sd10000, 0, 0);
		end
		send_item(thq_pkg::KIND_QUERY, 0, thq_pkg::H_W'($urandom), x, z);
	endtask

	// world coordinate around the grid, sometimes anywhere in the 24-bit range
	function automatic logic signed [thq_pkg::H_W-1:0] rand_coord(longint cnt);
		longint sp, half, c;
		if ($urandom_range(9) == 0)
			return thq_pkg::H_W'($urandom);
		if (cnt < 2) cnt = 2;
		if (cnt > 256) cnt = 256;
		sp = (heights_sb.spacing == 0) ? 1 : heights_sb.spacing;
		half = (cnt - 1) * sp / 2 + sp;
		c = longint'($urandom_range(2 * half)) - half;
		if (c > 8388607) c = 8388607;
		if (c < -8388608) c = -8388608;
		return thq_pkg::H_W'(c);
	endfunction

	function automatic logic [thq_pkg::ADDR_W-1:0] rand_grid_addr();
		int cols, rws;
		cols = heights_sb.columns < 2 ? 2 : (heights_sb.columns > 256 ? 256 : heights_sb.columns);
		rws = heights_sb.rows < 2 ? 2 : (heights_sb.rows > 256 ? 256 : heights_sb.rows);
		if ($urandom_range(7) == 0)
			return thq_pkg::ADDR_W'($urandom);
		return thq_pkg::ADDR_W'($urandom_range(rws - 1) * cols + $urandom_range(cols - 1));
	endfunction

	function automatic logic signed [thq_pkg::H_W-1:0] rand_height();
		case ($urandom_range(3))
			0: return thq_pkg::H_W'($urandom);
			1: return $urandom_range(1) ? 24'sh7FFFFF : 24'sh800000;
			default: return thq_pkg::H_W'($urandom_range(200000)) - 24'sd100000;
		endcase
	endfunction

	task automatic random_items(int n);
		int sel;
		logic [thq_pkg::ADDR_W-1:0] a;
		for (int i = 0; i < n; i++) begin
			sel = $urandom_range(99);
			if (sel < 40)
				query_at(rand_coord(heights_sb.columns), rand_coord(heights_sb.rows));
			else if (sel < 65)
				send_item(thq_pkg::KIND_LOAD, rand_grid_addr(), rand_height(),
					thq_pkg::H_W'($urandom), thq_pkg::H_W'($urandom));
			else if (sel < 90) begin
				// an add reads the entry, so it must hold a value already
				a = rand_grid_addr();
				if (!heights_sb.heights.exists(int'(a)))
					send_item(thq_pkg::KIND_LOAD, a, rand_height(), 0, 0);
				send_item(thq_pkg::KIND_ADD, a, rand_height(),
					thq_pkg::H_W'($urandom), thq_pkg::H_W'($urandom));
			end else
				send_item(thq_pkg::KIND_FLAT, rand_grid_addr(), thq_pkg::H_W'($urandom),
					thq_pkg::H_W'($urandom), thq_pkg::H_W'($urandom));
		end
	endtask

	// grid settings per phase; includes out-of-range counts and zero spacing
	int phase_cols[8] = '{256, 2, 0, 16'hFFFF, 256, 17, 3, 100};
	int phase_rows[8] = '{256, 2, 1, 511, 256, 5, 200, 37};
	int phase_sp[8]   = '{256, 1, 0, 256, 65535, 384, 1000, 16'h80};

	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: store extremes, add saturation, flatten, query corners
		send_item(thq_pkg::KIND_LOAD, 16'd0, 24'sh7FFFFF, 0, 0);
		send_item(thq_pkg::KIND_LOAD, 16'hFFFF, 24'sh800000, 0, 0);
		send_item(thq_pkg::KIND_ADD, 16'd0, 24'sh7FFFFF, 0, 0);
		send_item(thq_pkg::KIND_ADD, 16'hFFFF, 24'sh800000, 0, 0);
		send_item(thq_pkg::KIND_LOAD, 16'd1, 24'sd256, 0, 0);
		send_item(thq_pkg::KIND_LOAD, 16'd256, 24'sh800000, 0, 0);
		send_item(thq_pkg::KIND_LOAD, 16'd257, 24'sh7FFFFF, 0, 0);
		send_item(thq_pkg::KIND_ADD, 16'd1, -24'sd512, 0, 0);
		send_item(thq_pkg::KIND_FLAT, 16'd256, 24'sh7FFFFF, 0, 0);
		query_at(24'sh7FFFFF, 24'sh7FFFFF);
		query_at(24'sh800000, 24'sh800000);
		query_at(24'sh800000, 24'sh7FFFFF);
		query_at(24'sh7FFFFF, 24'sh800000);
		query_at(0, 0);
		query_at(-24'sd32640, 24'sd32640);       // top-left cell, upper triangle
		query_at(-24'sd32500, 24'sd32500);
		query_at(-24'sd32520, 24'sd32600);
		query_at(24'sd127, -24'sd129);           // lower triangle near centre
		wait_idle();
		write_reg(2'd3, 16'hFFFF);               // unused index, no effect
		query_at(24'sd1, 24'sd1);

		for (int p = 0; p < 8; p++) begin
			if (p != 0) begin
				wait_idle();
				write_reg(thq_pkg::REG_COLUMNS, thq_pkg::DATA_W'(phase_cols[p]));
				write_reg(thq_pkg::REG_ROWS, thq_pkg::DATA_W'(phase_rows[p]));
				write_reg(thq_pkg::REG_SPACING, thq_pkg::DATA_W'(phase_sp[p]));
			end
			idling_on = (p != 4);                // one phase back to back
			random_items(90);
		end

		wait_idle();
		if (heights_sb.errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	initial begin
		#50000000;
		$display("FAIL");
		$finish;
	end

endmodule
